// ----- design/url_percent_decoder_assert.svh -----
// Assertion macros shared by the command queue and the emitter.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define UPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("url_percent_decoder: assertion failed");

// Next-cycle implication, checked while out of reset.
`define UPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("url_percent_decoder: assertion failed");

`endif

// ----- design/upd_pkg.sv -----
package upd_pkg;

	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [3:0] LETTER_BASE = 4'd10;

	// One queued command: up to three output bytes produced by one input byte.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] data;
		logic            last;
	} cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return (c >= 8'h30 && c <= 8'h39) || (l >= 8'h61 && l <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] l;
		l = (c | 8'h20) - 8'h61;
		if (c >= 8'h30 && c <= 8'h39) begin
			return c[3:0];
		end
		return l[3:0] + LETTER_BASE;
	endfunction

endpackage

// ----- design/url_percent_decoder.sv -----
// URL percent decoder. Encoded text enters one byte per transaction, with
// in_last on the final byte of a string; decoded bytes leave one per
// transaction, with out_last on the final decoded byte. A '%' and two hex
// digits of either case become one byte (a zero byte included), '+' becomes
// a space, and all other bytes pass through. When a '%' is not followed by
// two hex digits, or the string ends first, the '%' and any held digit are
// emitted as they are and the current byte is decoded afresh, so one input
// byte yields zero to three output bytes. The input side accepts one
// transaction per cycle as long as the command queue (QUEUE_DEPTH entries)
// has room; the output side delivers one byte per cycle while out_ready is
// high, so an input byte that yields n bytes occupies the output for n
// transfers. An accepted input is first written into the queue and then
// loaded into the output register, from which its first byte leaves.
module url_percent_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import upd_pkg::*;

	// Front to queue: one command per accepted byte that yields output.
	logic q_push, q_push_ready;
	cmd_t q_push_cmd;

	// Queue to emitter.
	logic q_pop, q_pop_valid;
	cmd_t q_pop_cmd;

	// The front keeps the escape state and turns each byte into a command.
	// A byte that only extends an escape yields no command and is still
	// accepted, since the queue has room whenever in_ready is high.
	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_ready  (q_push_ready),
		.in_ready (in_ready),
		.q_push   (q_push),
		.q_cmd    (q_push_cmd)
	);

	// The queue decouples input stalls from output stalls.
	upd_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.push_ready (q_push_ready),
		.pop        (q_pop),
		.pop_valid  (q_pop_valid),
		.pop_cmd    (q_pop_cmd)
	);

	// The emitter holds one command in its output register and steps through
	// its bytes; the next command loads in the cycle the last byte leaves.
	upd_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_pop_valid),
		.q_cmd     (q_pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

// ----- design/upd_front.sv -----
module upd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          q_ready,
	output logic          in_ready,
	output logic          q_push,
	output upd_pkg::cmd_t q_cmd
);
	import upd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	phase_t     phase_q, phase_next;
	logic [7:0] held_q;
	logic       held_load;
	logic       accept;
	logic       pct, hex, plain_emit, use_plain;
	logic [7:0] plain_byte;
	logic [1:0] pre;
	cmd_t       cmd;

	assign accept   = in_valid && q_ready;
	assign in_ready = q_ready;

	always_comb begin
		pct        = (in_byte == CH_PERCENT);
		hex        = is_hex(in_byte);
		plain_emit = !pct || in_last;
		plain_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
		use_plain  = 1'b1;
		held_load  = 1'b0;
		pre        = 2'd0;
		phase_next = PH_IDLE;
		cmd.cnt    = 2'd0;
		cmd.data   = '0;
		cmd.last   = in_last;
		case (phase_q)
			PH_PCT: begin
				if (hex && !in_last) begin
					use_plain  = 1'b0;
					held_load  = 1'b1;
					phase_next = PH_DIGIT;
				end else begin
					pre = 2'd1;
				end
			end
			PH_DIGIT: begin
				if (hex) begin
					use_plain   = 1'b0;
					cmd.cnt     = 2'd1;
					cmd.data[0] = {hex_value(held_q), hex_value(in_byte)};
				end else begin
					pre = 2'd2;
				end
			end
			default: pre = 2'd0;
		endcase
		if (use_plain) begin
			// Held bytes of a broken escape come first, then the current byte.
			cmd.cnt     = pre + {1'b0, plain_emit};
			cmd.data[0] = (pre != 2'd0) ? CH_PERCENT : plain_byte;
			cmd.data[1] = (pre == 2'd2) ? held_q : plain_byte;
			cmd.data[2] = plain_byte;
			phase_next  = (pct && !in_last) ? PH_PCT : PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
			if (held_load) begin
				held_q <= in_byte;
			end
		end
	end

	assign q_push = accept && (cmd.cnt != 2'd0);
	assign q_cmd  = cmd;

endmodule

// ----- design/upd_cmd_fifo.sv -----
module upd_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upd_pkg::cmd_t push_cmd,
	output logic          push_ready,
	input  logic          pop,
	output logic          pop_valid,
	output upd_pkg::cmd_t pop_cmd
);
	import upd_pkg::*;

`include "url_percent_decoder_assert.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = slot_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`UPD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`UPD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1)
	`UPD_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1)

endmodule

// ----- design/upd_emitter.sv -----
module upd_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  upd_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import upd_pkg::*;

`include "url_percent_decoder_assert.svh"

	cmd_t       cmd_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       final_byte;
	logic       done;

	assign final_byte = (idx_q == cmd_q.cnt - 2'd1);
	assign done       = busy_q && out_ready && final_byte;
	assign q_pop      = q_valid && (!busy_q || done);
	assign out_valid  = busy_q;
	assign out_last   = cmd_q.last && final_byte;

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = cmd_q.data[0];
			2'd1:    out_byte = cmd_q.data[1];
			default: out_byte = cmd_q.data[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	`UPD_ASSERT_NOW(a_idx_in_range, busy_q, idx_q < cmd_q.cnt)
	`UPD_ASSERT_NOW(a_cmd_nonempty, busy_q, cmd_q.cnt != 2'd0)
	`UPD_ASSERT_NEXT(a_load_busy, q_pop, busy_q && idx_q == 2'd0)

endmodule

// ----- tb/tb.sv -----
module tb;

	import upd_pkg::*;

	// Character codes that the bench's own predictor needs beyond the package.
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_LC_A    = "a";
	localparam logic [7:0] CH_LC_F    = "f";
	localparam logic [7:0] CH_UC_A    = "A";
	localparam logic [7:0] CASE_BIT   = 8'h20;

	localparam int RANDOM_ITEMS   = 500;
	localparam int CALM_ITEMS     = 100;
	localparam int PRESSURE_ITEMS = 40;
	localparam int HOLD_CYCLES    = 150;
	localparam int TAIL_CYCLES    = 16;
	localparam int MAX_PRINTS     = 20;

	// Escape state of the predictor: nothing held, a '%' held, or a '%' and one digit held.
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PERCENT,
		ESC_ONE_DIGIT
	} esc_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dec_byte_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	// Predictor state and the decoded bytes still owed by the block, oldest first.
	esc_phase_t pred_phase = ESC_NONE;
	logic [7:0] pred_held  = 8'h00;
	dec_byte_t  decoded_q[$];

	// Idling controls. The input side is only touched by the stimulus process, so a
	// blocking flag is enough; the output flag is read by the output process and is
	// therefore written with nonblocking assignments.
	bit in_idle_on  = 1'b1;
	bit out_idle_on = 1'b1;

	// Each increment of hold_req asks the output process for one long hold-off.
	int hold_req  = 0;

	int n_errors       = 0;
	int n_items        = 0;
	int n_results      = 0;
	int n_escapes      = 0;
	int n_broken       = 0;
	int n_input_stalls = 0;

	url_percent_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Safety net: far longer than the slowest legal run, so only a hang ends here.
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_error(input string what, input logic [7:0] got,
			input logic [7:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS) begin
			$display("ERROR at %0t: %s: got %02h, expected %02h", $time, what, got, want);
		end
	endtask

	// Returns 1 when c is a hex digit of either case and gives its value in v.
	function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
		logic [7:0] folded;
		logic [7:0] t;
		folded = c | CASE_BIT;
		v = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
			v = t[3:0];
			return 1'b1;
		end
		if (folded >= CH_LC_A && folded <= CH_LC_F) begin
			t = folded - CH_LC_A + 8'd10;
			v = t[3:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void queue_decoded(input logic [7:0] b, input logic l);
		decoded_q.push_back('{data: b, last: l});
	endfunction

	// A byte seen with no escape pending.
	function automatic void predict_plain(input logic [7:0] c, input logic l);
		if (c == CH_PERCENT) begin
			// A '%' on the final byte has nothing to complete it, so it goes out as is.
			if (l) begin
				queue_decoded(CH_PERCENT, 1'b1);
				pred_phase = ESC_NONE;
			end else begin
				pred_phase = ESC_PERCENT;
			end
		end else if (c == CH_PLUS) begin
			queue_decoded(CH_SPACE, l);
			pred_phase = ESC_NONE;
		end else begin
			queue_decoded(c, l);
			pred_phase = ESC_NONE;
		end
	endfunction

	// Advances the predictor by one accepted input transaction and queues the
	// zero to three decoded bytes that it must produce.
	function automatic void predict_char(input logic [7:0] c, input logic l);
		logic [3:0] hi;
		logic [3:0] lo;
		logic       c_hex;
		c_hex = hex_nibble(c, lo);
		case (pred_phase)
			ESC_PERCENT: begin
				// The first digit may only be held if the string goes on after it.
				if (c_hex && !l) begin
					pred_held = c;
					pred_phase = ESC_ONE_DIGIT;
				end else begin
					queue_decoded(CH_PERCENT, 1'b0);
					n_broken++;
					predict_plain(c, l);
				end
			end
			ESC_ONE_DIGIT: begin
				if (c_hex) begin
					void'(hex_nibble(pred_held, hi));
					queue_decoded({hi, lo}, l);
					n_escapes++;
					pred_phase = ESC_NONE;
				end else begin
					// Broken after one digit: '%', the held digit, then this byte afresh.
					queue_decoded(CH_PERCENT, 1'b0);
					queue_decoded(pred_held, 1'b0);
					n_broken++;
					predict_plain(c, l);
				end
			end
			default: begin
				predict_plain(c, l);
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) begin
			return CH_ZERO + 8'(v);
		end
		return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] c;
		logic [3:0] v;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (hex_nibble(c, v));
		return c;
	endfunction

	// Offers one transaction and returns at the clock edge that accepts it. The
	// valid stays high afterwards, so back-to-back calls give a gapless stream;
	// whoever stops sending must lower it in the same time step.
	task automatic send_char(input logic [7:0] b, input logic l);
		int gap;
		int r;
		gap = 0;
		if (in_idle_on) begin
			r = $urandom_range(0, 99);
			if (r >= 90) begin
				gap = $urandom_range(8, 30);
			end else if (r >= 55) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_char(b, l);
		n_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	// Builds one string from random tokens and sends it with in_last on its final
	// byte. Most strings are well formed with some broken escapes mixed in; noise
	// strings are plain random bytes. Now and then the string is cut short so that
	// it can end inside an escape.
	task automatic send_random_string(input bit noise);
		logic [7:0] s[$];
		int         len;
		int         r;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
		while (s.size() < len) begin
			r = $urandom_range(0, 99);
			if (noise || r >= 60) begin
				s.push_back(8'($urandom_range(1, 255)));
			end else if (r < 30) begin
				s.push_back(CH_PERCENT);
				s.push_back(rand_hex_char());
				s.push_back(rand_hex_char());
			end else if (r < 40) begin
				s.push_back(CH_PLUS);
			end else if (r < 50) begin
				s.push_back(CH_PERCENT);
				if ($urandom_range(0, 1)) begin
					s.push_back(rand_hex_char());
				end
				s.push_back(rand_non_hex());
			end else begin
				s.push_back(CH_PERCENT);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			while (s.size() > len) begin
				void'(s.pop_back());
			end
		end
		foreach (s[i]) begin
			send_char(s[i], i == s.size() - 1);
		end
	endtask

	// Stops offering input and waits until every owed decoded byte has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Smallest and largest legal bytes pass through; a '+' at the end becomes a
	// space carrying out_last.
	task automatic test_plain_bytes();
		send_char(8'h01, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_PLUS, 1'b1);
		drain();
	endtask

	// Upper, lower and mixed case digits, a decoded zero byte, and an escape that
	// completes on the final byte of the string.
	task automatic test_valid_escapes();
		send_text("%41%4a%00%Ff");
		drain();
	endtask

	// A '%' followed by a non-digit, one digit then a non-digit, and a '%' that
	// breaks a pending escape and starts its own.
	task automatic test_broken_escapes();
		send_text("%G%4%%4+");
		drain();
	endtask

	// Strings that end while an escape is pending: a lone '%', a '%' whose digit
	// is the final byte, and a flush of three bytes with the last one flagged.
	task automatic test_end_inside_escape();
		send_text("%");
		send_text("%4");
		send_text("%a%");
		drain();
	endtask

	// The output side holds off for a long stretch while input keeps coming with
	// no gaps, so the command queue fills and in_ready drops.
	task automatic test_backpressure();
		int start;
		start = n_items;
		in_idle_on = 1'b0;
		hold_req <= hold_req + 1;
		while (n_items < start + PRESSURE_ITEMS) begin
			send_random_string(1'b0);
		end
		in_idle_on = 1'b1;
		drain();
	endtask

	// Random strings: first a stretch with no idling on either side, then with
	// random gaps and stalls, with an occasional pause until all output is in.
	task automatic test_random_traffic();
		int start;
		start = n_items;
		in_idle_on = 1'b0;
		out_idle_on <= 1'b0;
		while (n_items < start + CALM_ITEMS) begin
			send_random_string($urandom_range(0, 6) == 0);
		end
		in_idle_on = 1'b1;
		out_idle_on <= 1'b1;
		while (n_items < start + RANDOM_ITEMS) begin
			send_random_string($urandom_range(0, 6) == 0);
			if ($urandom_range(0, 29) == 0) begin
				drain();
			end
		end
		drain();
	endtask

	// Output side: checks each accepted transaction against the oldest owed byte,
	// then chooses out_ready for the next cycle. Everything is read at the edge,
	// before any nonblocking update of that edge lands, so the order of processes
	// within the time step does not matter.
	always @(posedge clk) begin : out_side
		dec_byte_t want;
		int        hold_seen;
		int        hold_left;
		int        stall_left;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				report_error("decoded byte with none expected", out_byte, 8'h00);
			end else begin
				want = decoded_q.pop_front();
				n_results++;
				if (out_byte !== want.data) begin
					report_error("out_byte", out_byte, want.data);
				end
				if (out_last !== want.last) begin
					report_error("out_last", {7'd0, out_last}, {7'd0, want.last});
				end
			end
		end
		if (arst_n && in_valid && !in_ready) begin
			n_input_stalls++;
		end
		// A new hold request restarts the long hold-off, counted here in cycles.
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
			// Mostly short stalls, now and then a long one.
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
				: $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h01;
		in_last <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_plain_bytes();
		test_valid_escapes();
		test_broken_escapes();
		test_end_inside_escape();
		test_backpressure();
		test_random_traffic();

		// Allow for the pipeline latency so that any stray output is still caught.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d input bytes and %0d decoded bytes, %0d hex escapes, %0d broken.",
			n_items, n_results, n_escapes, n_broken);
		$display("Input was held back by output back-pressure for %0d cycles.",
			n_input_stalls);
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/upd_pkg.sv
design/upd_front.sv
design/upd_cmd_fifo.sv
design/upd_emitter.sv
design/url_percent_decoder.sv
tb/tb.sv
